// ===== rtl/core/rpi_pkg.sv =====
// Shared types and constants for the ray/plane intersection unit.
package rpi_pkg;

    localparam int WORD_W = 32;
    localparam int THR_W  = 31;

    localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] plane_normal_x;
        logic signed [WORD_W-1:0] plane_normal_y;
        logic signed [WORD_W-1:0] plane_normal_z;
        logic signed [WORD_W-1:0] plane_offset;
        logic signed [WORD_W-1:0] origin_x;
        logic signed [WORD_W-1:0] origin_y;
        logic signed [WORD_W-1:0] origin_z;
        logic signed [WORD_W-1:0] direction_x;
        logic signed [WORD_W-1:0] direction_y;
        logic signed [WORD_W-1:0] direction_z;
    } t_in_item;

    typedef struct packed {
        logic                     crosses;
        logic signed [WORD_W-1:0] distance;
        logic signed [WORD_W-1:0] hit_x;
        logic signed [WORD_W-1:0] hit_y;
        logic signed [WORD_W-1:0] hit_z;
    } t_out_item;

    // Line geometry carried from the front end to the back end.
    typedef struct packed {
        logic signed [WORD_W-1:0] origin_x;
        logic signed [WORD_W-1:0] origin_y;
        logic signed [WORD_W-1:0] origin_z;
        logic signed [WORD_W-1:0] direction_x;
        logic signed [WORD_W-1:0] direction_y;
        logic signed [WORD_W-1:0] direction_z;
    } t_geom;

endpackage

// ===== rtl/core/ray_plane_intersection_unit.sv =====
// Top level of the ray/plane intersection unit.
//
//   Channel   Handshake                 Payload
//   in        i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   out       o_out_valid / i_out_stall o_out_data (t_out_item)
//   cfg       i_cfg_valid / o_cfg_ready i_cfg_data (parallel threshold)
//
// One item is accepted per cycle while the input is not stalled; an item passes through
// 3 front stages, one queue slot, 34 divider stages (one quotient bit each) and
// 4 back stages. The divider holds most of the depth; throughput is one beat per
// cycle unless a stall holds it. Reset is synchronous; the threshold resets to 1
// and no clearing pass is needed. A stalled output beat freezes the back end; the
// four-entry queue lets the front keep accepting until it fills.
module ray_plane_intersection_unit
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [THR_W-1:0] i_cfg_data
);
    localparam int DW = 66 - FRAC_BITS;
    localparam int QW = 1 + 2 * DW + $bits(t_geom);

    logic [THR_W-1:0]     r_threshold;
    logic                 push, pop, full, empty;
    t_geom                f_geom, b_geom;
    logic signed [DW-1:0] f_num, f_den, b_num, b_den;
    logic                 f_crosses, b_crosses;
    logic [QW-1:0]        q_in, q_out;

    // Threshold register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_W'(1);
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_data),
        .i_full      (full),
        .o_push      (push),
        .o_geom      (f_geom),
        .o_num       (f_num),
        .o_den       (f_den),
        .o_crosses   (f_crosses)
    );

    assign q_in = {f_crosses, f_num, f_den, f_geom};
    assign {b_crosses, b_num, b_den, b_geom} = q_out;

    rpi_fifo #(.WIDTH(QW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!empty),
        .o_pop       (pop),
        .i_num       (b_num),
        .i_den       (b_den),
        .i_crosses   (b_crosses),
        .i_geom      (b_geom),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_data)
    );

endmodule

// ===== rtl/core/rpi_front.sv =====
// Front end: accepts items, forms both dot products and classifies parallel lines.
module rpi_front
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [THR_W-1:0]         i_threshold,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_item                 i_item,
    input  logic                     i_full,
    output logic                     o_push,
    output t_geom                    o_geom,
    output logic signed [65-FRAC_BITS:0] o_num,
    output logic signed [65-FRAC_BITS:0] o_den,
    output logic                     o_crosses
);
    localparam int DW = 66 - FRAC_BITS;
    localparam logic signed [65:0] HALF = 66'(1) <<< (FRAC_BITS - 1);

    logic             fe;
    logic             r_s1_valid, r_s2_valid, r_s3_valid;
    t_in_item         r_s1_item;
    logic signed [63:0] r_s2_pd [3];
    logic signed [63:0] r_s2_po [3];
    logic signed [WORD_W-1:0] r_s2_w;
    t_geom            r_s2_geom;
    logic signed [65:0] den_sum, num_sum;
    logic signed [DW-1:0] den_rnd, num_rnd;
    logic [DW-1:0]    den_mag;
    logic             parallel;
    logic signed [DW-1:0] r_s3_num, r_s3_den;
    logic             r_s3_crosses;
    t_geom            r_s3_geom;

    // The whole front freezes only when its last beat cannot enter the queue.
    assign fe      = !(r_s3_valid && i_full);
    assign o_stall = !fe;
    assign o_push  = r_s3_valid && !i_full;

    // Valid bits of the three front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (fe) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Stage 1 registers the input beat; stage 2 forms the six products.
    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_s1_item  <= i_item;
            r_s2_pd[0] <= r_s1_item.direction_x * r_s1_item.plane_normal_x;
            r_s2_pd[1] <= r_s1_item.direction_y * r_s1_item.plane_normal_y;
            r_s2_pd[2] <= r_s1_item.direction_z * r_s1_item.plane_normal_z;
            r_s2_po[0] <= r_s1_item.origin_x * r_s1_item.plane_normal_x;
            r_s2_po[1] <= r_s1_item.origin_y * r_s1_item.plane_normal_y;
            r_s2_po[2] <= r_s1_item.origin_z * r_s1_item.plane_normal_z;
            r_s2_w     <= r_s1_item.plane_offset;
            r_s2_geom  <= '{origin_x:    r_s1_item.origin_x,
                           origin_y:    r_s1_item.origin_y,
                           origin_z:    r_s1_item.origin_z,
                           direction_x: r_s1_item.direction_x,
                           direction_y: r_s1_item.direction_y,
                           direction_z: r_s1_item.direction_z};
        end
    end

    // Exact sums, rounded half up to the working fraction, then the parallel test.
    always_comb begin
        den_sum  = 66'(r_s2_pd[0]) + 66'(r_s2_pd[1]) + 66'(r_s2_pd[2]) + HALF;
        num_sum  = 66'(r_s2_po[0]) + 66'(r_s2_po[1]) + 66'(r_s2_po[2]) + HALF;
        den_rnd  = DW'(den_sum >>> FRAC_BITS);
        num_rnd  = DW'(num_sum >>> FRAC_BITS) + DW'(r_s2_w);
        den_mag  = den_rnd[DW-1] ? DW'(-den_rnd) : DW'(den_rnd);
        parallel = (den_rnd == '0) || (den_mag < DW'(i_threshold));
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_s3_num     <= num_rnd;
            r_s3_den     <= den_rnd;
            r_s3_crosses <= !parallel;
            r_s3_geom    <= r_s2_geom;
        end
    end

    assign o_num     = r_s3_num;
    assign o_den     = r_s3_den;
    assign o_crosses = r_s3_crosses;
    assign o_geom    = r_s3_geom;

endmodule

// ===== rtl/core/rpi_fifo.sv =====
// Short queue that decouples the front end from the back end.
module rpi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/rpi_back.sv =====
// Back end: restoring divider pipeline for t, then the intersection point.
module rpi_back
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  logic signed [65-FRAC_BITS:0] i_num,
    input  logic signed [65-FRAC_BITS:0] i_den,
    input  logic                         i_crosses,
    input  t_geom                        i_geom,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output t_out_item                    o_out_item
);
    localparam int DW = 66 - FRAC_BITS;
    localparam int RW = DW + 34;
    localparam int NS = 34;
    localparam logic signed [64:0] HALF = 65'(1) <<< (FRAC_BITS - 1);

    logic be;

    // Division stage registers; index 0 is the entry stage.
    logic              r_v    [NS+1];
    logic [RW-1:0]     r_rem  [NS+1];
    logic [DW-1:0]     r_b    [NS+1];
    logic [NS-1:0]     r_q    [NS+1];
    logic              r_neg  [NS+1];
    logic              r_cr   [NS+1];
    t_geom             r_geom [NS+1];

    logic [NS:0]       qr;
    logic [NS-1:0]     qmag;
    logic signed [WORD_W-1:0] t_sat;
    logic              r_t_v, r_t_cr;
    logic signed [WORD_W-1:0] r_t;
    t_geom             r_t_geom;
    logic              r_m_v, r_m_cr;
    logic signed [WORD_W-1:0] r_m_t;
    logic signed [63:0] r_m_p [3];
    t_geom             r_m_geom;
    logic signed [WORD_W-1:0] hit [3];
    logic              r_out_valid;
    t_out_item         r_out_item;

    // The whole back end advances unless a finished beat waits at the output.
    assign be    = !(r_out_valid && i_out_stall);
    assign o_pop = be && i_valid;

    // Entry stage: magnitudes and quotient sign for t = -num / den.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (be) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_rem[0]  <= RW'(i_num[DW-1] ? DW'(-i_num) : DW'(i_num)) << (FRAC_BITS + 1);
            r_b[0]    <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_q[0]    <= '0;
            r_neg[0]  <= ((i_num != '0) && !i_num[DW-1]) != i_den[DW-1];
            r_cr[0]   <= i_crosses;
            r_geom[0] <= i_geom;
        end
    end

    // One quotient bit per stage, from the overflow bit down to the round bit.
    for (genvar k = 0; k < NS; k++) begin : g_div
        localparam int BIT = NS - 1 - k;
        logic [RW-1:0] b_sh;
        logic          ge;

        assign b_sh = RW'(r_b[k]) << BIT;
        assign ge   = (r_rem[k] >= b_sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (be) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (be) begin
                r_rem[k+1]  <= ge ? r_rem[k] - b_sh : r_rem[k];
                r_q[k+1]    <= r_q[k] | (NS'(ge) << BIT);
                r_b[k+1]    <= r_b[k];
                r_neg[k+1]  <= r_neg[k];
                r_cr[k+1]   <= r_cr[k];
                r_geom[k+1] <= r_geom[k];
            end
        end
    end

    // Round half away from zero, saturate to 32 bits and apply the sign.
    always_comb begin
        qr   = ({1'b0, 1'b0, r_q[NS][NS-2:0]} + (NS+1)'(1)) >> 1;
        qmag = r_q[NS][NS-1] ? NS'(64'h1_0000_0000) : NS'(qr);
        if (r_neg[NS]) begin
            t_sat = (qmag > NS'(64'h8000_0000)) ? S32_MIN : WORD_W'(-qmag);
        end else begin
            t_sat = (qmag > NS'(64'h7FFF_FFFF)) ? S32_MAX : WORD_W'(qmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
            r_m_v <= 1'b0;
        end else if (be) begin
            r_t_v <= r_v[NS];
            r_m_v <= r_t_v;
        end
    end

    // Register t, then form the three direction products.
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_t      <= t_sat;
            r_t_cr   <= r_cr[NS];
            r_t_geom <= r_geom[NS];
            r_m_p[0] <= r_t_geom.direction_x * r_t;
            r_m_p[1] <= r_t_geom.direction_y * r_t;
            r_m_p[2] <= r_t_geom.direction_z * r_t;
            r_m_t    <= r_t;
            r_m_cr   <= r_t_cr;
            r_m_geom <= r_t_geom;
        end
    end

    // Round each product half up, add the origin and saturate.
    always_comb begin
        logic signed [WORD_W-1:0] org [3];
        logic signed [65:0]       s;
        org[0] = r_m_geom.origin_x;
        org[1] = r_m_geom.origin_y;
        org[2] = r_m_geom.origin_z;
        for (int i = 0; i < 3; i++) begin
            s = 66'(org[i]) + 66'((65'(r_m_p[i]) + HALF) >>> FRAC_BITS);
            if (s > 66'(S32_MAX)) begin
                hit[i] = S32_MAX;
            end else if (s < 66'(S32_MIN)) begin
                hit[i] = S32_MIN;
            end else begin
                hit[i] = WORD_W'(s);
            end
        end
    end

    // Output register; a parallel line reports all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (be) begin
            r_out_valid <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            if (r_m_cr) begin
                r_out_item <= '{crosses: 1'b1, distance: r_m_t,
                                hit_x: hit[0], hit_y: hit[1], hit_z: hit[2]};
            end else begin
                r_out_item <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/rpi_checker.sv =====
// Port-level checks for the ray/plane intersection unit, bound to the top level.
module rpi_checker
    import rpi_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data,
    input logic      o_cfg_ready
);
    // A stalled output beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // A parallel result carries only zeros.
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.crosses |->
            o_out_data.distance == '0 && o_out_data.hit_x == '0 &&
            o_out_data.hit_y == '0 && o_out_data.hit_z == '0)
        else $error("parallel result is not zero");

    // Reset empties the pipeline and opens the input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state after reset is wrong");

    // The configuration port always takes a write.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind ray_plane_intersection_unit rpi_checker u_rpi_checker (.*);

// ===== tb/ray_plane_intersection_unit_checker.sv =====
// Checker for the ray/plane intersection unit: predicts each result and compares it.
`timescale 1ns / 1ps

module ray_plane_intersection_unit_checker
    import rpi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_data,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [THR_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_hit_count,
    output int               o_parallel_count
);

    localparam int FB = 16;

    t_out_item        expected_hits[$];
    logic [THR_W-1:0] threshold;

    // Exact three-term dot product, rounded half up to FB fractional bits.
    function automatic logic signed [95:0] dot_rounded(
        input logic signed [31:0] a0, b0, a1, b1, a2, b2);
        logic signed [95:0] acc;
        acc = 96'(a0) * 96'(b0);
        acc = acc + 96'(a1) * 96'(b1);
        acc = acc + 96'(a2) * 96'(b2);
        return (acc + (96'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic logic signed [31:0] sat_word(input logic signed [95:0] v);
        if (v > 96'sh7FFF_FFFF) return S32_MAX;
        if (v < -96'sh8000_0000) return S32_MIN;
        return v[31:0];
    endfunction

    // Expected intersection for one item under the current threshold.
    function automatic t_out_item predict_hit(input t_in_item it, input logic [THR_W-1:0] thr);
        t_out_item          res;
        logic signed [95:0] den, num, mag, a, b, q, r, t96, p;
        logic signed [31:0] t;
        logic               neg;
        res = '0;
        den = dot_rounded(it.direction_x, it.plane_normal_x, it.direction_y,
                          it.plane_normal_y, it.direction_z, it.plane_normal_z);
        mag = den < 0 ? -den : den;
        if (den == 0 || mag < $signed({65'b0, thr})) return res;
        num = dot_rounded(it.origin_x, it.plane_normal_x, it.origin_y,
                          it.plane_normal_y, it.origin_z, it.plane_normal_z)
              + 96'(it.plane_offset);
        num = -num;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = mag;
        // Quotient rounded to nearest, ties away from zero; overflow saturates.
        if (a / b >= (96'sd1 <<< (32 - FB))) begin
            q = 96'sd1 <<< 32;
        end else begin
            q = (a <<< FB) / b;
            r = (a <<< FB) % b;
            if ((r <<< 1) >= b) q = q + 1;
        end
        if (neg) t96 = q > 96'sh8000_0000 ? -96'sh8000_0000 : -q;
        else     t96 = q > 96'sh7FFF_FFFF ? 96'sh7FFF_FFFF : q;
        t = t96[31:0];
        res.crosses  = 1'b1;
        res.distance = t;
        p = 96'(it.direction_x) * 96'(t);
        res.hit_x = sat_word(96'(it.origin_x) + ((p + (96'sd1 <<< (FB - 1))) >>> FB));
        p = 96'(it.direction_y) * 96'(t);
        res.hit_y = sat_word(96'(it.origin_y) + ((p + (96'sd1 <<< (FB - 1))) >>> FB));
        p = 96'(it.direction_z) * 96'(t);
        res.hit_z = sat_word(96'(it.origin_z) + ((p + (96'sd1 <<< (FB - 1))) >>> FB));
        return res;
    endfunction

    assign o_pending = expected_hits.size();

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            threshold        = 31'd1;
            o_fail_count     = 0;
            o_hit_count      = 0;
            o_parallel_count = 0;
            expected_hits.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) threshold = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                exp_item = predict_hit(i_in_data, threshold);
                if (exp_item.crosses) o_hit_count++;
                else o_parallel_count++;
                expected_hits.push_back(exp_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    exp_item = expected_hits.pop_front();
                    if (exp_item.crosses !== i_out_data.crosses ||
                        exp_item.distance !== i_out_data.distance ||
                        exp_item.hit_x !== i_out_data.hit_x ||
                        exp_item.hit_y !== i_out_data.hit_y ||
                        exp_item.hit_z !== i_out_data.hit_z) begin
                        $display("%0t: mismatch crosses/distance/x/y/z expected %b %h %h %h %h",
                                 $time, exp_item.crosses, exp_item.distance,
                                 exp_item.hit_x, exp_item.hit_y, exp_item.hit_z);
                        $display("%0t:                                   actual %b %h %h %h %h",
                                 $time, i_out_data.crosses, i_out_data.distance,
                                 i_out_data.hit_x, i_out_data.hit_y, i_out_data.hit_z);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/ray_plane_intersection_unit_tb.sv =====
// Testbench top for the ray/plane intersection unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module ray_plane_intersection_unit_tb;
    import rpi_pkg::*;

    localparam int LATENCY = 42;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data = '0;

    int fail_count, pending, hit_count, parallel_count;
    int beats_sent = 0;
    int beats_received = 0;
    bit hold_request = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ray_plane_intersection_unit u_top (.*);

    ray_plane_intersection_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hit_count(hit_count), .o_parallel_count(parallel_count)
    );

    initial begin
        #20_000_000;
        $display("ray_plane_intersection_unit_tb: errors");
        $finish;
    end

    // Count result beats as they leave.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) beats_received++;
    end

    // Receiver stalls in random modes; a requested hold-off stalls for a long stretch.
    always begin
        int mode, span, hold_cycles;
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
        if (hold_request) begin
            hold_request = 0;
            hold_cycles  = 0;
            while (hold_cycles < 300) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                hold_cycles++;
            end
        end
        repeat (span) begin
            @(negedge i_clk);
            case (mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic t_in_item make_ray(
        input logic signed [31:0] nx, ny, nz, w, ox, oy, oz, dx, dy, dz);
        t_in_item it;
        it = '{nx, ny, nz, w, ox, oy, oz, dx, dy, dz};
        return it;
    endfunction

    function automatic logic signed [31:0] rand_word(input int lim);
        return $signed($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Random ray: mostly plausible geometry, some raw noise and tiny values.
    function automatic t_in_item random_ray();
        t_in_item it;
        int       kind;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            it = make_ray(rand_word(65536), rand_word(65536), rand_word(65536),
                          rand_word(1 << 24), rand_word(1 << 24), rand_word(1 << 24),
                          rand_word(1 << 24), rand_word(1 << 20), rand_word(1 << 20),
                          rand_word(1 << 20));
        end else if (kind < 85) begin
            it = make_ray($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            it = make_ray(rand_word(4), rand_word(4), rand_word(70000), rand_word(8),
                          rand_word(8), rand_word(8), rand_word(8), rand_word(4),
                          rand_word(4), rand_word(70000));
        end
        return it;
    endfunction

    // Offer one beat and hold it until accepted.
    task automatic send_ray(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (beats_received != beats_sent) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Corner rays: extremes, parallel, on-plane origin, rounding ties, saturation.
    task automatic send_corner_rays();
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, ONE, 0, 0, 0, 5 * ONE, 0, 0, -ONE));
        send_ray(make_ray(0, ONE, 0, -2 * ONE, 7, 2 * ONE, -3, ONE, ONE, ONE));
        send_ray(make_ray(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                          S32_MAX, S32_MAX, S32_MAX));
        send_ray(make_ray(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                          S32_MIN, S32_MIN, S32_MIN));
        send_ray(make_ray(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN,
                          S32_MAX, S32_MIN, S32_MAX));
        send_ray(make_ray(0, 0, ONE, 0, 0, 0, -ONE, 0, 0, 1));
        send_ray(make_ray(0, 0, ONE, 0, 0, 0, ONE, 0, 0, -1));
        send_ray(make_ray(0, 0, 32'sh8000, 0, 0, 0, 3, 0, 0, 1));
        send_ray(make_ray(0, 0, ONE, ONE, S32_MAX, S32_MIN, -ONE, ONE, -ONE, ONE));
        send_ray(make_ray(ONE, 0, 0, 0, S32_MIN, 0, 0, 3 * ONE, 0, 0));
        send_ray(make_ray(0, 0, 3 * ONE, ONE, 0, 0, 0, 0, 0, 3 * ONE));
        send_ray(make_ray(0, 0, ONE, 0, 0, 0, -32'sh8000, 0, 0, ONE));
        send_ray(make_ray(0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE));
    endtask

    // One phase: corner rays, then random rays in bursts with gaps, then a drain.
    task automatic run_phase(input int count, input bit with_hold);
        int sent;
        sent = 0;
        send_corner_rays();
        while (sent < count) begin
            int burst;
            burst = $urandom_range(1, 40);
            if (with_hold && sent > count / 2) begin
                hold_request = 1;
                with_hold    = 0;
            end
            repeat (burst) begin
                send_ray(random_ray());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_phase(500, 1);
        write_threshold(31'd0);
        run_phase(400, 0);
        write_threshold(31'h7FFF_FFFF);
        run_phase(150, 0);
        write_threshold(31'h0001_0000);
        run_phase(400, 1);
        write_threshold(THR_W'($urandom_range(1, 31'h7FFF_FFFF)));
        run_phase(150, 0);
        write_threshold(31'd2);
        run_phase(300, 0);

        $display("Sent %0d rays over six threshold settings including 0 and the maximum.",
                 beats_sent);
        $display("Predicted %0d crossings and %0d parallel rays.", hit_count, parallel_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ray_plane_intersection_unit_tb: clean");
        end else begin
            if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
            $display("ray_plane_intersection_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rpi_pkg.sv
rtl/core/rpi_front.sv
rtl/core/rpi_fifo.sv
rtl/core/rpi_back.sv
rtl/core/ray_plane_intersection_unit.sv
rtl/core/rpi_checker.sv
tb/ray_plane_intersection_unit_checker.sv
tb/ray_plane_intersection_unit_tb.sv
